// ===== src/psms_pkg.sv =====
// Shared types, codes and helpers for the power supply mode supervisor.
package psms_pkg;

   // Mode codes as reported on the result channel
   localparam logic [2:0] MODE_POWERON = 3'd0;
   localparam logic [2:0] MODE_STANDBY = 3'd1;
   localparam logic [2:0] MODE_SOFT    = 3'd2;
   localparam logic [2:0] MODE_CC      = 3'd3;
   localparam logic [2:0] MODE_CV      = 3'd4;
   localparam logic [2:0] MODE_CP      = 3'd5;
   localparam logic [2:0] MODE_FAULT   = 3'd6;
   localparam logic [2:0] MODE_UNKNOWN = 3'd7;

   // Relay / PWM command codes
   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_ON   = 2'd1;
   localparam logic [1:0] CMD_OFF  = 2'd2;

   // output_mode register codes
   localparam logic [1:0] OUT_MODE_CC = 2'd0;
   localparam logic [1:0] OUT_MODE_CV = 2'd1;
   localparam logic [1:0] OUT_MODE_CP = 2'd2;

   // Configuration register indexes
   localparam logic [2:0] REG_LONG_WAIT     = 3'd0;
   localparam logic [2:0] REG_STANDBY_RETRY = 3'd1;
   localparam logic [2:0] REG_PRECHARGE_MIN = 3'd2;
   localparam logic [2:0] REG_SS_TARGET     = 3'd3;
   localparam logic [2:0] REG_SS_BAND       = 3'd4;
   localparam logic [2:0] REG_OUTPUT_MODE   = 3'd5;
   localparam logic [2:0] REG_RAMP_LIMIT    = 3'd6;
   localparam logic [2:0] REG_RAMP_STEP     = 3'd7;

   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 32;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [15:0] CNT_MAX  = 16'hFFFF;
   localparam logic [9:0]  VOLT_MAX = 10'h3FF;

   typedef enum logic [6:0] {
      ST_POWERON = 7'b0000001,
      ST_STANDBY = 7'b0000010,
      ST_SOFT    = 7'b0000100,
      ST_CC      = 7'b0001000,
      ST_CV      = 7'b0010000,
      ST_CP      = 7'b0100000,
      ST_FAULT   = 7'b1000000
   } mode_state_type;

   typedef struct packed {
      logic [15:0] long_wait_ticks;
      logic [15:0] standby_retry_ticks;
      logic [9:0]  precharge_volt_min;
      logic [9:0]  softstart_target;
      logic [7:0]  softstart_band;
      logic [1:0]  output_mode;
      logic [9:0]  ramp_limit;
      logic [5:0]  ramp_step;
   } cfg_type;

   typedef struct packed {
      logic       ev_turn_on;
      logic       ev_turn_off;
      logic       ev_fault;
      logic       ev_tick;
      logic       adc_offset_ready;
      logic       in_soft_relay_closed;
      logic       out_soft_relay_closed;
      logic       in_main_relay_closed;
      logic       out_main_relay_closed;
      logic       grid_ok;
      logic       dc_pwm_active;
      logic [9:0] bus_volt;
   } item_type;

   typedef struct packed {
      mode_state_type mode;
      logic           precharge_done;
      logic [15:0]    precharge_cnt;
      logic [15:0]    standby_cnt;
      logic [15:0]    softstart_cnt;
      logic [9:0]     ref_volts;
      logic           fail_flag;
      logic           pending_turn_on;
   } state_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [1:0] in_soft_relay_cmd;
      logic [1:0] out_soft_relay_cmd;
      logic       in_main_relay_on;
      logic [1:0] out_main_relay_cmd;
      logic [1:0] pfc_pwm_cmd;
      logic [1:0] buck_pwm_cmd;
      logic       pfc_ctrl_reset;
      logic       dc_ctrl_reset;
      logic [9:0] bus_ref;
      logic       softstart_fail;
   } result_type;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == CNT_MAX) ? CNT_MAX : v + 16'd1;
   endfunction

   function automatic logic [2:0] mode_code(input mode_state_type m);
      logic [2:0] code;
      unique case (m)
         ST_POWERON: code = MODE_POWERON;
         ST_STANDBY: code = MODE_STANDBY;
         ST_SOFT:    code = MODE_SOFT;
         ST_CC:      code = MODE_CC;
         ST_CV:      code = MODE_CV;
         ST_CP:      code = MODE_CP;
         ST_FAULT:   code = MODE_FAULT;
         default:    code = MODE_UNKNOWN;
      endcase
      return code;
   endfunction

endpackage

// ===== src/psms_step.sv =====
// Next-state and command logic for one event set of the supervisor.
module psms_step import psms_pkg::*; (
   input  cfg_type    cfg,
   input  state_type  cur,
   input  item_type   item,
   output state_type  nxt,
   output result_type res
);

   logic        on;
   logic [10:0] ramp_sum;
   logic [10:0] bus_plus_band;
   logic [10:0] win_hi;
   logic        in_window;
   logic        pc_ready;
   logic [1:0]  isr, osr, omr, pfc, buck;
   logic        imr, pfcrst, dcrst;

   assign on            = item.ev_turn_on | cur.pending_turn_on;
   assign ramp_sum      = {1'b0, cur.ref_volts} + {5'b0, cfg.ramp_step};
   // lower bound below zero admits zero, so compare bus + band against target
   assign bus_plus_band = {1'b0, item.bus_volt} + {3'b0, cfg.softstart_band};
   assign win_hi        = {1'b0, cfg.softstart_target} + {3'b0, cfg.softstart_band};
   assign in_window     = (bus_plus_band >= {1'b0, cfg.softstart_target}) &&
                          ({1'b0, item.bus_volt} <= win_hi);
   assign pc_ready      = (cur.precharge_cnt >= cfg.long_wait_ticks) &&
                          (item.bus_volt >= cfg.precharge_volt_min);

   always_comb begin
      nxt                 = cur;
      nxt.pending_turn_on = 1'b0;
      isr    = CMD_NONE;
      osr    = CMD_NONE;
      omr    = CMD_NONE;
      pfc    = CMD_NONE;
      buck   = CMD_NONE;
      imr    = 1'b0;
      pfcrst = 1'b0;
      dcrst  = 1'b0;

      unique case (cur.mode)
         ST_POWERON: begin
            if (item.ev_fault) begin
               pfc      = CMD_OFF;
               buck     = CMD_OFF;
               nxt.mode = ST_FAULT;
            end else if (item.ev_tick && item.adc_offset_ready && !cur.precharge_done) begin
               if (pc_ready) begin
                  // soft relays are commanded off and the input main relay on
                  nxt.precharge_cnt  = '0;
                  nxt.precharge_done = 1'b1;
                  isr                = CMD_OFF;
                  osr                = CMD_OFF;
                  imr                = 1'b1;
                  nxt.mode           = ST_STANDBY;
               end else begin
                  nxt.precharge_cnt = sat_inc(cur.precharge_cnt);
                  if (!item.in_soft_relay_closed)  isr = CMD_ON;
                  if (!item.out_soft_relay_closed) osr = CMD_ON;
               end
            end
         end
         ST_STANDBY: begin
            if (on && item.in_main_relay_closed && item.grid_ok) begin
               pfcrst            = 1'b1;
               pfc               = CMD_ON;
               buck              = CMD_ON;
               nxt.softstart_cnt = '0;
               nxt.mode          = ST_SOFT;
            end else if (item.ev_turn_off) begin
               pfc  = CMD_OFF;
               buck = CMD_OFF;
            end else if (item.ev_fault) begin
               pfc      = CMD_OFF;
               buck     = CMD_OFF;
               nxt.mode = ST_FAULT;
            end else if (item.ev_tick) begin
               if (item.out_main_relay_closed) omr = CMD_OFF;
               // retry compare uses the incremented count
               if (sat_inc(cur.standby_cnt) >= cfg.standby_retry_ticks) begin
                  nxt.standby_cnt     = '0;
                  nxt.pending_turn_on = 1'b1;
               end else begin
                  nxt.standby_cnt = sat_inc(cur.standby_cnt);
               end
            end
         end
         ST_SOFT, ST_CC, ST_CV, ST_CP: begin
            if (item.ev_turn_off) begin
               pfc      = CMD_OFF;
               buck     = CMD_OFF;
               nxt.mode = ST_STANDBY;
            end else if (item.ev_fault) begin
               pfc      = CMD_OFF;
               buck     = CMD_OFF;
               nxt.mode = ST_FAULT;
            end else if (cur.mode == ST_SOFT && item.ev_tick) begin
               if (cur.ref_volts < cfg.ramp_limit) begin
                  nxt.ref_volts = ramp_sum[10] ? VOLT_MAX : ramp_sum[9:0];
               end
               if (in_window && cfg.output_mode == OUT_MODE_CC) begin
                  nxt.mode = ST_CC;
               end else if (in_window && cfg.output_mode == OUT_MODE_CV) begin
                  nxt.mode = ST_CV;
               end else if (in_window && cfg.output_mode == OUT_MODE_CP) begin
                  nxt.mode = ST_CP;
               end else if (cur.softstart_cnt >= cfg.long_wait_ticks) begin
                  pfc               = CMD_OFF;
                  buck              = CMD_OFF;
                  nxt.mode          = ST_FAULT;
                  nxt.softstart_cnt = '0;
                  nxt.fail_flag     = 1'b1;
               end else begin
                  nxt.softstart_cnt = sat_inc(cur.softstart_cnt);
               end
            end else if (cur.mode == ST_CC && item.ev_tick) begin
               if (!item.out_main_relay_closed) begin
                  omr = CMD_ON;
               end else if (!item.dc_pwm_active) begin
                  dcrst = 1'b1;
                  buck  = CMD_ON;
               end
            end
         end
         default: begin
            // fault is terminal; nothing else is reachable
         end
      endcase
   end

   always_comb begin
      res.mode               = mode_code(nxt.mode);
      res.in_soft_relay_cmd  = isr;
      res.out_soft_relay_cmd = osr;
      res.in_main_relay_on   = imr;
      res.out_main_relay_cmd = omr;
      res.pfc_pwm_cmd        = pfc;
      res.buck_pwm_cmd       = buck;
      res.pfc_ctrl_reset     = pfcrst;
      res.dc_ctrl_reset      = dcrst;
      res.bus_ref            = nxt.ref_volts;
      res.softstart_fail     = nxt.fail_flag;
   end

endmodule

// ===== src/power_supply_mode_supervisor.sv =====
// Top level of the power supply mode supervisor: stream ports, registers, checks.
//
// Each req_ transaction carries one event set (turn-on, turn-off, fault, tick)
// with relay, grid, PWM and bus-voltage status. Each one yields exactly one
// rsp_ transaction with the new mode, relay/PWM commands, controller reset
// pulses, the ramped bus reference and the sticky soft-start-fail flag.
// Registers must be written through csr_we/csr_index/csr_wdata only while idle;
// the block itself does not enforce this.
// A request lands in the input register, then the step logic updates the mode
// state and loads the result register when the result is not stalled.
// One transaction per cycle while rsp_tready keeps up; the step logic between the
// input register and the result register is combinational.
// When rsp_tready is low the result register holds; the input register takes
// one more request, then req_tready drops until the result is taken.
// Reset (synchronous, active high) returns to power-on mode, clears all
// counters, the reference and the fail flag, empties both registers and
// loads the register defaults.
module power_supply_mode_supervisor import psms_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [0] ev_turn_on [1] ev_turn_off [2] ev_fault [3] ev_tick [4] adc_offset_ready
   // [5] in_soft_relay_closed [6] out_soft_relay_closed [7] in_main_relay_closed
   // [8] out_main_relay_closed [9] grid_ok [10] dc_pwm_active [20:11] bus_volt
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [2:0] mode [4:3] in_soft_relay_cmd [6:5] out_soft_relay_cmd [7] in_main_relay_on
   // [9:8] out_main_relay_cmd [11:10] pfc_pwm_cmd [13:12] buck_pwm_cmd
   // [14] pfc_ctrl_reset [15] dc_ctrl_reset [25:16] bus_ref [26] softstart_fail
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_nxt;
   item_type   item_ff, item_in;
   logic       item_valid_ff, item_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type res_ff, res_nxt;
   logic       advance;

   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;

   always_comb begin
      item_in.ev_turn_on            = req_tdata[0];
      item_in.ev_turn_off           = req_tdata[1];
      item_in.ev_fault              = req_tdata[2];
      item_in.ev_tick               = req_tdata[3];
      item_in.adc_offset_ready      = req_tdata[4];
      item_in.in_soft_relay_closed  = req_tdata[5];
      item_in.out_soft_relay_closed = req_tdata[6];
      item_in.in_main_relay_closed  = req_tdata[7];
      item_in.out_main_relay_closed = req_tdata[8];
      item_in.grid_ok               = req_tdata[9];
      item_in.dc_pwm_active         = req_tdata[10];
      item_in.bus_volt              = req_tdata[20:11];
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_tvalid && req_tready) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_LONG_WAIT:     cfg_in.long_wait_ticks     = csr_wdata;
            REG_STANDBY_RETRY: cfg_in.standby_retry_ticks = csr_wdata;
            REG_PRECHARGE_MIN: cfg_in.precharge_volt_min  = csr_wdata[9:0];
            REG_SS_TARGET:     cfg_in.softstart_target    = csr_wdata[9:0];
            REG_SS_BAND:       cfg_in.softstart_band      = csr_wdata[7:0];
            REG_OUTPUT_MODE:   cfg_in.output_mode         = csr_wdata[1:0];
            REG_RAMP_LIMIT:    cfg_in.ramp_limit          = csr_wdata[9:0];
            REG_RAMP_STEP:     cfg_in.ramp_step           = csr_wdata[5:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   psms_step u_step (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .item (item_ff),
      .nxt  (state_nxt),
      .res  (res_nxt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff                  <= 1'b0;
         rsp_valid_ff                   <= 1'b0;
         cfg_ff.long_wait_ticks         <= 16'd500;
         cfg_ff.standby_retry_ticks     <= 16'd100;
         cfg_ff.precharge_volt_min      <= 10'd0;
         cfg_ff.softstart_target        <= 10'd0;
         cfg_ff.softstart_band          <= 8'd0;
         cfg_ff.output_mode             <= OUT_MODE_CC;
         cfg_ff.ramp_limit              <= 10'd700;
         cfg_ff.ramp_step               <= 6'd5;
         state_ff.mode                  <= ST_POWERON;
         state_ff.precharge_done        <= 1'b0;
         state_ff.precharge_cnt         <= '0;
         state_ff.standby_cnt           <= '0;
         state_ff.softstart_cnt         <= '0;
         state_ff.ref_volts             <= '0;
         state_ff.fail_flag             <= 1'b0;
         state_ff.pending_turn_on       <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         cfg_ff        <= cfg_in;
         if (advance) state_ff <= state_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) item_ff <= item_in;
      if (advance)                  res_ff  <= res_nxt;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0,
                        res_ff.softstart_fail,
                        res_ff.bus_ref,
                        res_ff.dc_ctrl_reset,
                        res_ff.pfc_ctrl_reset,
                        res_ff.buck_pwm_cmd,
                        res_ff.pfc_pwm_cmd,
                        res_ff.out_main_relay_cmd,
                        res_ff.in_main_relay_on,
                        res_ff.out_soft_relay_cmd,
                        res_ff.in_soft_relay_cmd,
                        res_ff.mode};

   // fault mode is terminal
   a_fault_terminal: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode == ST_FAULT |=> state_ff.mode == ST_FAULT)
      else $error("left fault mode");

   // soft-start fail flag is sticky
   a_fail_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.fail_flag |=> state_ff.fail_flag)
      else $error("softstart fail flag cleared");

   // precharge completes only once
   a_precharge_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.precharge_done |=> state_ff.precharge_done)
      else $error("precharge done cleared");

   // a held request must not be dropped while the result stalls
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && rsp_valid_ff && !rsp_tready |=> item_valid_ff && $stable(item_ff))
      else $error("pending request lost during stall");

endmodule
